// ----- hw/rtl/peltier_heat_cool_mode_switch_assert.svh -----
// Assertion macros used by the Peltier mode switch core module.
`ifndef PELTIER_HEAT_COOL_MODE_SWITCH_ASSERT_SVH
`define PELTIER_HEAT_COOL_MODE_SWITCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PMSW_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pmsw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PMSW_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pmsw assertion failed");

`endif

// ----- hw/rtl/pmsw_pkg.sv -----
`timescale 1ns / 1ps

package pmsw_pkg;

  // Field widths.
  localparam int unsigned ReqW   = 11;
  localparam int unsigned MsW    = 10;
  localparam int unsigned SetW   = 10;
  localparam int unsigned DeadW  = 14;
  localparam int unsigned TimerW = 16;
  localparam int unsigned HeatW  = 10;
  localparam int unsigned CoolW  = 11;
  localparam int unsigned OffW   = 9;
  localparam int unsigned DirW   = 2;
  localparam int unsigned CfgIdxW = 1;

  // Fan latch thresholds.
  localparam logic signed [ReqW-1:0] FanOffAbove = 11'sd120;
  localparam logic signed [ReqW-1:0] FanOnBelow  = -11'sd600;

  // Timer saturation value.
  localparam logic [TimerW-1:0] TimerMax = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [SetW-1:0]  CoolSetpointReset = 10'd250;
  localparam logic [DeadW-1:0] DeadTimeReset     = 14'd1000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COOL_SETPOINT = 1'b0,
    CFG_DEAD_TIME     = 1'b1
  } cfg_idx_t;

  // Steady direction codes.
  localparam logic [DirW-1:0] DirNone = 2'b00;
  localparam logic [DirW-1:0] DirHeat = 2'b01;
  localparam logic [DirW-1:0] DirCool = 2'b11;

  // Configuration values handed to the datapath.
  typedef struct packed {
    logic [SetW-1:0]  cool_setpoint;
    logic [DeadW-1:0] dead_time_ms;
  } cfg_t;

  // Cooling offset picked by the setpoint, first bound that holds wins.
  function automatic logic [OffW-1:0] cool_offset(input logic [SetW-1:0] sp);
    logic [OffW-1:0] off;
    priority if (sp <= 10'd220) off = 9'd450;
    else if (sp <= 10'd240) off = 9'd400;
    else if (sp <= 10'd250) off = 9'd365;
    else if (sp <= 10'd280) off = 9'd300;
    else if (sp <= 10'd300) off = 9'd200;
    else if (sp <= 10'd310) off = 9'd180;
    else if (sp <= 10'd320) off = 9'd170;
    else if (sp <= 10'd330) off = 9'd160;
    else off = 9'd20;
    return off;
  endfunction

endpackage

// ----- hw/rtl/pmsw_cfg.sv -----
`timescale 1ns / 1ps

module pmsw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pmsw_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pmsw_pkg::DeadW-1:0]        cfg_data,
  output pmsw_pkg::cfg_t                    cfg
);

  pmsw_pkg::cfg_idx_t idx;

  assign idx = pmsw_pkg::cfg_idx_t'(cfg_index);

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cool_setpoint <= pmsw_pkg::CoolSetpointReset;
      cfg.dead_time_ms  <= pmsw_pkg::DeadTimeReset;
    end else if (cfg_write) begin
      unique case (idx)
        pmsw_pkg::CFG_COOL_SETPOINT: begin
          cfg.cool_setpoint <= cfg_data[pmsw_pkg::SetW-1:0];
        end
        pmsw_pkg::CFG_DEAD_TIME: begin
          cfg.dead_time_ms <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pmsw_core.sv -----
`timescale 1ns / 1ps
`include "peltier_heat_cool_mode_switch_assert.svh"

module pmsw_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [pmsw_pkg::ReqW-1:0]    req,
  input  logic [pmsw_pkg::MsW-1:0]            ms,
  input  pmsw_pkg::cfg_t                      cfg,
  output logic [pmsw_pkg::HeatW-1:0]          heat_drive,
  output logic [pmsw_pkg::CoolW-1:0]          cool_drive,
  output logic                                fan_on,
  output logic signed [pmsw_pkg::DirW-1:0]    direction
);

  // Mode state; the drive and fan registers double as the result word.
  logic                              active_cooling;
  logic                              active_cooling_next;
  logic [pmsw_pkg::TimerW-1:0]       switch_timer;
  logic [pmsw_pkg::TimerW-1:0]       switch_timer_next;
  logic                              fan_latch;
  logic                              fan_latch_next;
  logic [pmsw_pkg::HeatW-1:0]        heat_level;
  logic [pmsw_pkg::HeatW-1:0]        heat_level_next;
  logic [pmsw_pkg::CoolW-1:0]        cool_level;
  logic [pmsw_pkg::CoolW-1:0]        cool_level_next;
  logic [pmsw_pkg::DirW-1:0]         steady_dir;
  logic [pmsw_pkg::DirW-1:0]         steady_dir_next;

  logic                              want_cool;
  logic [pmsw_pkg::TimerW:0]         timer_sum;
  logic [pmsw_pkg::TimerW-1:0]       timer_sat;
  logic                              in_dead;
  logic signed [pmsw_pkg::CoolW:0]   cool_calc;

  assign want_cool = req[pmsw_pkg::ReqW-1];

  // Dead-time accumulation with saturation.
  assign timer_sum = {1'b0, switch_timer} + {{(pmsw_pkg::TimerW + 1 - pmsw_pkg::MsW){1'b0}}, ms};
  assign timer_sat = timer_sum[pmsw_pkg::TimerW] ? pmsw_pkg::TimerMax
                                                 : timer_sum[pmsw_pkg::TimerW-1:0];
  assign in_dead   = timer_sat <=
                     {{(pmsw_pkg::TimerW - pmsw_pkg::DeadW){1'b0}}, cfg.dead_time_ms};

  // Cooling drive is the table offset minus the (negative) request.
  assign cool_calc = $signed({3'b000, pmsw_pkg::cool_offset(cfg.cool_setpoint)})
                   - $signed({req[pmsw_pkg::ReqW-1], req});

  // Next state for one tick.
  always_comb begin
    active_cooling_next = active_cooling;
    switch_timer_next   = switch_timer;
    fan_latch_next      = fan_latch;
    heat_level_next     = heat_level;
    cool_level_next     = cool_level;
    steady_dir_next     = steady_dir;

    priority if (req > pmsw_pkg::FanOffAbove) fan_latch_next = 1'b0;
    else if (req < pmsw_pkg::FanOnBelow) fan_latch_next = 1'b1;
    else fan_latch_next = fan_latch;

    if (want_cool != active_cooling) begin
      if (in_dead) begin
        switch_timer_next = timer_sat;
        heat_level_next   = '0;
        cool_level_next   = '0;
      end else begin
        switch_timer_next   = '0;
        active_cooling_next = want_cool;
      end
    end else if (!want_cool) begin
      steady_dir_next = pmsw_pkg::DirHeat;
      heat_level_next = req[pmsw_pkg::HeatW-1:0];
    end else begin
      steady_dir_next = pmsw_pkg::DirCool;
      cool_level_next = cool_calc[pmsw_pkg::CoolW-1:0];
    end
  end

  // State update on every accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cooling <= 1'b0;
      switch_timer   <= '0;
      fan_latch      <= 1'b0;
      heat_level     <= '0;
      cool_level     <= '0;
      steady_dir     <= pmsw_pkg::DirNone;
    end else if (take) begin
      active_cooling <= active_cooling_next;
      switch_timer   <= switch_timer_next;
      fan_latch      <= fan_latch_next;
      heat_level     <= heat_level_next;
      cool_level     <= cool_level_next;
      steady_dir     <= steady_dir_next;
    end
  end

  assign heat_drive = heat_level;
  assign cool_drive = cool_level;
  assign fan_on     = fan_latch;
  assign direction  = $signed(steady_dir);

  // A tick inside the dead time leaves both drives off.
  `PMSW_ASSERT_NXT(a_dead_drives_off, clk, rst, take && (want_cool != active_cooling) && in_dead, (heat_level == '0) && (cool_level == '0))

  // The active mode only changes together with a timer clear.
  `PMSW_ASSERT_IMP(a_mode_change_clears_timer, clk, rst, active_cooling != $past(active_cooling), switch_timer == '0)

  // The steady direction only moves on an accepted tick.
  `PMSW_ASSERT_IMP(a_dir_moves_on_take, clk, rst, steady_dir != $past(steady_dir), $past(take))

endmodule

// ----- hw/rtl/peltier_heat_cool_mode_switch.sv -----
`timescale 1ns / 1ps

// Peltier heat/cool mode switch. Each input word carries a signed drive
// request and the milliseconds since the previous tick; each one yields
// exactly one result word with the heating and cooling PWM compare values,
// the fan latch and the last steady direction. A change of sign in the
// request starts a dead time during which both drives are forced off, after
// which the new mode is adopted. The block takes one word per clock cycle
// when the result side is not stalled; a word goes through an input register
// and one pass of compare-and-select logic into the state registers, which
// also hold the result, so a result word is valid once the state registers
// have taken its input word from the input register.
// Configuration writes are taken at any time and should be made while idle.
module peltier_heat_cool_mode_switch (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pmsw_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pmsw_pkg::DeadW-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pmsw_pkg::ReqW-1:0]    drive_request,
  input  logic [pmsw_pkg::MsW-1:0]            elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pmsw_pkg::HeatW-1:0]          heat_drive,
  output logic [pmsw_pkg::CoolW-1:0]          cool_drive,
  output logic                                fan_on,
  output logic signed [pmsw_pkg::DirW-1:0]    direction
);

  pmsw_pkg::cfg_t                   cfg;
  logic                             s1_valid;
  logic signed [pmsw_pkg::ReqW-1:0] s1_req;
  logic [pmsw_pkg::MsW-1:0]         s1_ms;
  logic                             advance;
  logic                             take;

  pmsw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result slot frees up when it is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_req <= drive_request;
      s1_ms  <= elapsed_ms;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  pmsw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req        (s1_req),
    .ms         (s1_ms),
    .cfg        (cfg),
    .heat_drive (heat_drive),
    .cool_drive (cool_drive),
    .fan_on     (fan_on),
    .direction  (direction)
  );

endmodule

// ----- sim/mode_switch_checker.sv -----
`timescale 1ns / 1ps

// Watches the word channels and the register port of the Peltier mode switch,
// predicts every result word and compares it with the word the block returns.
module mode_switch_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pmsw_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pmsw_pkg::DeadW-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [pmsw_pkg::ReqW-1:0]    drive_request,
  input  logic [pmsw_pkg::MsW-1:0]            elapsed_ms,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [pmsw_pkg::HeatW-1:0]          heat_drive,
  input  logic [pmsw_pkg::CoolW-1:0]          cool_drive,
  input  logic                                fan_on,
  input  logic signed [pmsw_pkg::DirW-1:0]    direction,
  output int                                  fail_count,
  output int                                  pending
);
  import pmsw_pkg::*;

  typedef struct packed {
    logic [HeatW-1:0] heat;
    logic [CoolW-1:0] cool;
    logic             fan;
    logic [DirW-1:0]  dir;
  } drive_word_t;

  // Mirror of the block's registers and state.
  logic [SetW-1:0]   setpoint_mirror;
  logic [DeadW-1:0]  dead_time_mirror;
  logic              cooling_active;
  logic [TimerW-1:0] switch_ms;
  logic              fan_latched;
  logic [CoolW-1:0]  heat_lvl;
  logic [CoolW-1:0]  cool_lvl;
  logic [DirW-1:0]   steady_dir;

  drive_word_t expected_drives[$];
  int mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Cooling offset for a setpoint; the first bound that holds wins.
  function automatic int offset_for_setpoint(input logic [SetW-1:0] sp);
    int off;
    if (sp <= 220) off = 450;
    else if (sp <= 240) off = 400;
    else if (sp <= 250) off = 365;
    else if (sp <= 280) off = 300;
    else if (sp <= 300) off = 200;
    else if (sp <= 310) off = 180;
    else if (sp <= 320) off = 170;
    else if (sp <= 330) off = 160;
    else off = 20;
    return off;
  endfunction

  // Advances the mirrored state by one tick and queues the word it yields.
  task automatic advance_mode_state(input logic signed [ReqW-1:0] req,
                                    input logic [MsW-1:0] ms);
    logic        want_cool;
    logic [16:0] sum;
    int          req_val;
    drive_word_t word;
    req_val = req;
    want_cool = (req_val < 0);

    // The fan latch has a wide hysteresis band between the two thresholds.
    if (req_val > 120) fan_latched = 1'b0;
    else if (req_val < -600) fan_latched = 1'b1;

    if (want_cool != cooling_active) begin
      // Requested mode differs: run the dead time with both drives off.
      sum = {1'b0, switch_ms} + {7'd0, ms};
      switch_ms = (sum > 17'(TimerMax)) ? TimerMax : sum[TimerW-1:0];
      if (switch_ms <= {2'b00, dead_time_mirror}) begin
        heat_lvl = '0;
        cool_lvl = '0;
      end else begin
        // The switch tick adopts the mode but writes neither drive.
        switch_ms = '0;
        cooling_active = want_cool;
      end
    end else if (!want_cool) begin
      steady_dir = DirHeat;
      heat_lvl = CoolW'(req_val);
    end else begin
      steady_dir = DirCool;
      cool_lvl = CoolW'(offset_for_setpoint(setpoint_mirror) - req_val);
    end

    word.heat = heat_lvl[HeatW-1:0];
    word.cool = cool_lvl;
    word.fan = fan_latched;
    word.dir = steady_dir;
    expected_drives.push_back(word);
  endtask

  function automatic void compare_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      setpoint_mirror = CoolSetpointReset;
      dead_time_mirror = DeadTimeReset;
      cooling_active = 1'b0;
      switch_ms = '0;
      fan_latched = 1'b0;
      heat_lvl = '0;
      cool_lvl = '0;
      steady_dir = DirNone;
      expected_drives.delete();
    end else begin
      // Register writes land at the same edge as in the block.
      if (cfg_write) begin
        if (cfg_index == CFG_COOL_SETPOINT) setpoint_mirror = cfg_data[SetW-1:0];
        else dead_time_mirror = cfg_data;
      end

      if (in_valid && !in_stall) advance_mode_state(drive_request, elapsed_ms);

      // Each accepted result word is held against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $error("result word with no prediction: heat_drive %0d, cool_drive %0d",
                 heat_drive, cool_drive);
          mismatches++;
        end else begin
          drive_word_t want;
          want = expected_drives.pop_front();
          compare_field("heat_drive", {6'd0, want.heat}, {6'd0, heat_drive});
          compare_field("cool_drive", {5'd0, want.cool}, {5'd0, cool_drive});
          compare_field("fan_on", {15'd0, want.fan}, {15'd0, fan_on});
          compare_field("direction", {{14{want.dir[1]}}, want.dir},
                        {{14{direction[1]}}, direction});
        end
      end
    end
    pending <= expected_drives.size();
    fail_count <= mismatches;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pmsw_pkg::*;

  localparam int CycleLimit = 100000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  cfg_idx_t                cfg_index = CFG_COOL_SETPOINT;
  logic [DeadW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [ReqW-1:0]  drive_request = '0;
  logic [MsW-1:0]          elapsed_ms = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [HeatW-1:0]        heat_drive;
  logic [CoolW-1:0]        cool_drive;
  logic                    fan_on;
  logic signed [DirW-1:0]  direction;

  int fail_count;
  int pending;
  int cycles = 0;
  bit idle_on = 1'b1;

  peltier_heat_cool_mode_switch i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .drive_request (drive_request),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .heat_drive    (heat_drive),
    .cool_drive    (cool_drive),
    .fan_on        (fan_on),
    .direction     (direction)
  );

  mode_switch_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .drive_request (drive_request),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .heat_drive    (heat_drive),
    .cool_drive    (cool_drive),
    .fan_on        (fan_on),
    .direction     (direction),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always #6 clk = ~clk;

  // The result side stalls at random while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 15);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one tick word, with random gaps first, and waits until it is taken.
  task automatic send_tick(input logic signed [ReqW-1:0] req, input logic [MsW-1:0] ms);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drive_request <= req;
    elapsed_ms <= ms;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off the sender until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DeadW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // A request on the wanted side, sometimes right at a fan threshold.
  function automatic logic signed [ReqW-1:0] random_request(input bit cool_side);
    int val;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: val = 120;
        1: val = 121;
        2: val = -600;
        default: val = -601;
      endcase
    end else if (cool_side) begin
      val = -int'($urandom_range(1024, 1));
    end else begin
      val = $urandom_range(1023, 0);
    end
    return ReqW'(val);
  endfunction

  // Runs of requests on one side with occasional sign flips, so that dead
  // times run out and modes change; a tenth of the words are plain noise.
  task automatic random_phase(input int count, input int dead);
    bit cool_side;
    int span;
    cool_side = $urandom_range(1);
    span = dead / 3 + 2;
    if (span > 1023) span = 1023;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) cool_side = !cool_side;
      if ($urandom_range(99) < 10) begin
        send_tick(ReqW'($urandom), MsW'($urandom));
      end else if ($urandom_range(99) < 80) begin
        send_tick(random_request(cool_side), MsW'($urandom_range(span, 0)));
      end else begin
        send_tick(random_request(cool_side), MsW'($urandom_range(1023, 0)));
      end
    end
  endtask

  initial begin
    int bounds[18];
    int dead;

    bounds = '{220, 221, 240, 241, 250, 251, 280, 281, 300, 301,
               310, 311, 320, 321, 330, 331, 0, 1023};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: heat steady, a full dead time into cooling and back.
    send_tick(11'sd0, 10'd0);
    send_tick(11'sd1023, 10'd0);
    send_tick(-11'sd1, 10'd0);
    send_tick(-11'sd601, 10'd1000);
    send_tick(-11'sd600, 10'd1);
    send_tick(-11'sd1024, 10'd0);
    send_tick(11'sd120, 10'd0);
    send_tick(11'sd121, 10'd1023);
    send_tick(11'sd1000, 10'd0);
    drain_results();

    // Lowest setpoint with no dead time at all.
    write_reg(CFG_COOL_SETPOINT, 14'd0);
    write_reg(CFG_DEAD_TIME, 14'd0);
    send_tick(-11'sd1000, 10'd0);
    send_tick(-11'sd500, 10'd1);
    send_tick(-11'sd1, 10'd0);
    drain_results();

    // Out-of-range setpoint and the longest dead time.
    write_reg(CFG_COOL_SETPOINT, 14'd1023);
    write_reg(CFG_DEAD_TIME, 14'd16383);
    send_tick(-11'sd1024, 10'd0);
    send_tick(11'sd0, 10'd1023);
    send_tick(-11'sd5, 10'd512);
    drain_results();

    // Random phases walk the setpoint across every offset bound.
    for (int p = 0; p < 18; p++) begin
      case ($urandom_range(5))
        0: dead = 0;
        1: dead = 1;
        2: dead = 10000;
        3: dead = 16383;
        default: dead = $urandom_range(400, 0);
      endcase
      write_reg(CFG_COOL_SETPOINT, DeadW'(bounds[p]));
      write_reg(CFG_DEAD_TIME, DeadW'(dead));
      idle_on = !(p >= 6 && p <= 8);
      random_phase(45, dead);
      drain_results();
    end
    idle_on = 1'b1;

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pmsw_pkg.sv
hw/rtl/pmsw_cfg.sv
hw/rtl/pmsw_core.sv
hw/rtl/peltier_heat_cool_mode_switch.sv
sim/mode_switch_checker.sv
sim/tb_top.sv
